[design/blpd_pkg.sv]
// Shared types and codes for the bounded list positional delete unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package blpd_pkg;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 8;
  localparam int IO_W     = 32;
  localparam int LEN_W    = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_RM_HEAD = 3'd1,
    CMD_RM_TAIL = 3'd2,
    CMD_RM_POS  = 3'd3,
    CMD_RM_MID  = 3'd4,
    CMD_DUMP    = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NO_EFFECT = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } ctl_state_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_EXEC = 2'd1,
    OP_DUMP = 2'd2
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic dump_more;
  } dp_sts_t;

endpackage

`default_nettype wire

[design/bounded_list_positional_delete_unit.sv]
// Bounded list unit: append, remove head/tail/position/middle, dump.
// Non-dump word: one per cycle while busy is low, result strobed in the cycle after acceptance.
// Dump of n entries: n results, one per cycle, the first strobed in the cycle after
// acceptance; busy is high while the cell row rotates one entry per cycle.
// Reset (rst_n low, synchronous) empties the list; the receiver cannot stall.
// Depends on blpd_pkg, blpd_ctrl, blpd_datapath.
`timescale 1ns / 1ps
`default_nettype none

module bounded_list_positional_delete_unit
  import blpd_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [CMD_W-1:0]       in_command,
  input  wire logic signed [IO_W-1:0] in_value,
  input  wire logic [POS_W-1:0]       in_position,
  output logic                        out_valid,
  output logic signed [IO_W-1:0]      out_value_res,
  output logic                        out_last,
  output logic                        out_empty_list,
  output logic [LEN_W-1:0]            out_length,
  output logic [STATUS_W-1:0]         out_status
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  blpd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  blpd_datapath #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_command     (in_command),
    .in_value       (in_value),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_value_res  (out_value_res),
    .out_last       (out_last),
    .out_empty_list (out_empty_list),
    .out_length     (out_length),
    .out_status     (out_status)
  );

endmodule

`default_nettype wire

[design/blpd_ctrl.sv]
// Controller: accepts command words and sequences multi-cycle dumps.
// Depends on blpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module blpd_ctrl
  import blpd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire dp_sts_t  sts,
  output ctl_cmd_t      cmd,
  output logic          busy
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start && sts.dump_more) begin
          state_nxt = S_DUMP;
        end
      end
      S_DUMP: begin
        if (!sts.dump_more) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    busy   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_EXEC;
        end
      end
      S_DUMP: begin
        cmd.op = OP_DUMP;
        busy   = 1'b1;
      end
      default: begin
        cmd.op = OP_NONE;
        busy   = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/blpd_datapath.sv]
// Datapath: row of entry cells with shift-to-close removal, rotate-out dump,
// entry count and registered result word. Depends on blpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module blpd_datapath
  import blpd_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ctl_cmd_t            cmd,
  output dp_sts_t                  sts,
  input  wire logic [CMD_W-1:0]    in_command,
  input  wire logic signed [IO_W-1:0] in_value,
  input  wire logic [POS_W-1:0]    in_position,
  output logic                     out_valid,
  output logic signed [IO_W-1:0]   out_value_res,
  output logic                     out_last,
  output logic                     out_empty_list,
  output logic [LEN_W-1:0]         out_length,
  output logic [STATUS_W-1:0]      out_status
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [WORD_WIDTH-1:0] entries_r   [CAPACITY];
  logic [WORD_WIDTH-1:0] entries_nxt [CAPACITY];
  logic [WORD_WIDTH-1:0] nbr         [CAPACITY];
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         k_r, k_nxt;

  logic                  valid_r;
  logic [IO_W-1:0]       value_r;
  logic                  last_r;
  logic                  empty_r;
  logic [LEN_W-1:0]      length_r;
  status_t               status_r;

  logic [WORD_WIDTH-1:0] app_word;
  logic [IO_W-1:0]       head_word;
  logic                  res_valid;
  logic [IO_W-1:0]       res_value;
  logic                  res_last;
  status_t               res_status;
  logic                  app, rm_en, rot, dump_more;
  logic [CW-1:0]         rm_idx;
  logic                  pos_ok;

  generate
    if (WORD_WIDTH <= IO_W) begin : g_narrow
      assign app_word = in_value[WORD_WIDTH-1:0];
    end else begin : g_wide
      assign app_word = {{(WORD_WIDTH-IO_W){in_value[IO_W-1]}}, in_value};
    end
    if (WORD_WIDTH >= IO_W) begin : g_out_trunc
      assign head_word = entries_r[0][IO_W-1:0];
    end else begin : g_out_sext
      assign head_word = {{(IO_W-WORD_WIDTH){entries_r[0][WORD_WIDTH-1]}}, entries_r[0]};
    end
    for (genvar i = 0; i < CAPACITY; i++) begin : g_nbr
      if (i < CAPACITY - 1) begin : g_mid
        assign nbr[i] = entries_r[i+1];
      end else begin : g_end
        assign nbr[i] = entries_r[i];
      end
    end
  endgenerate

  assign pos_ok = (in_position != '0) &&
                  (CMPW'(in_position) <= CMPW'(count_r));

  always_comb begin
    k_nxt      = k_r;
    res_valid  = 1'b0;
    res_value  = '0;
    res_last   = 1'b1;
    res_status = ST_NO_EFFECT;
    app        = 1'b0;
    rm_en      = 1'b0;
    rm_idx     = '0;
    rot        = 1'b0;
    dump_more  = 1'b0;
    unique case (cmd.op)
      OP_EXEC: begin
        res_valid = 1'b1;
        case (cmd_t'(in_command))
          CMD_APPEND: begin
            if (count_r >= CAP_C) begin
              res_status = ST_FULL;
            end else begin
              app        = 1'b1;
              res_status = ST_DONE;
            end
          end
          CMD_RM_HEAD: begin
            rm_en  = (count_r != '0);
            rm_idx = '0;
          end
          CMD_RM_TAIL: begin
            rm_en  = (count_r != '0);
            rm_idx = count_r - CW'(1);
          end
          CMD_RM_POS: begin
            rm_en  = pos_ok;
            rm_idx = CW'(in_position - POS_W'(1));
          end
          CMD_RM_MID: begin
            rm_en  = (count_r != '0);
            rm_idx = count_r >> 1;
          end
          CMD_DUMP: begin
            res_status = ST_DONE;
            if (count_r != '0) begin
              rot       = 1'b1;
              res_value = head_word;
              res_last  = (count_r == CW'(1));
              dump_more = (count_r != CW'(1));
              k_nxt     = CW'(1);
            end
          end
          default: res_status = ST_NO_EFFECT;
        endcase
        if (rm_en) begin
          res_status = ST_DONE;
        end
      end
      OP_DUMP: begin
        res_valid  = 1'b1;
        res_status = ST_DONE;
        rot        = 1'b1;
        res_value  = head_word;
        res_last   = (k_r == count_r - CW'(1));
        dump_more  = !res_last;
        k_nxt      = k_r + CW'(1);
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_nxt[i] = entries_r[i];
      if (app && (CW'(i) == count_r)) begin
        entries_nxt[i] = app_word;
      end else if (rm_en && (CW'(i) >= rm_idx)) begin
        entries_nxt[i] = nbr[i];
      end else if (rot) begin
        entries_nxt[i] = (CW'(i) == count_r - CW'(1)) ? entries_r[0] : nbr[i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (app) begin
      count_nxt = count_r + CW'(1);
    end else if (rm_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign sts.dump_more = dump_more;

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_r[i] <= entries_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      k_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      k_r     <= k_nxt;
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      value_r  <= res_value;
      last_r   <= res_last;
      empty_r  <= (count_nxt == '0);
      length_r <= LEN_W'(count_nxt);
      status_r <= res_status;
    end
  end

  assign out_valid      = valid_r;
  assign out_value_res  = value_r;
  assign out_last       = last_r;
  assign out_empty_list = empty_r;
  assign out_length     = length_r;
  assign out_status     = status_r;

endmodule

`default_nettype wire
